>>> rtl/core/ftr_pkg.sv
// Shared types and constants for the fan tach period-to-rate filter.
// No dependencies; imported by every module of the block.
`default_nettype none

package ftr_pkg;

   localparam int FAN_W   = 3;
   localparam int CAP_W   = 32;
   localparam int RATE_W  = 16;
   localparam int ACC_W   = 28;
   localparam int SHIFT_W = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   localparam logic [CAP_W-1:0]   WRAP_LIMIT       = 32'hFFFF_FFFF;
   localparam logic [RATE_W-1:0]  RATE_MAX         = 16'hFFFF;
   localparam logic [SHIFT_W-1:0] MAX_SHIFT        = 4'd12;
   localparam logic [CAP_W-1:0]   REF_CLOCK_RESET  = 32'd1_000_000;
   localparam logic [SHIFT_W-1:0] SHIFT_RESET      = 4'd4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REF_CLOCK    = 1'b0,
      CSR_FILTER_SHIFT = 1'b1
   } csr_index_type;

   // write request from the sequencer into the per-fan store
   typedef struct packed {
      logic             edge_we;   // also marks the fan as seen
      logic             acc_we;    // also marks the filter as seeded
      logic [FAN_W-1:0] fan;
      logic [CAP_W-1:0] edge_val;
      logic [ACC_W-1:0] acc_val;
   } store_wr_type;

   // read view of one fan's state
   typedef struct packed {
      logic             seen;
      logic             seeded;
      logic [CAP_W-1:0] last_edge;
      logic [ACC_W-1:0] acc;
   } store_rd_type;

endpackage

`default_nettype wire

>>> rtl/core/ftr_divider.sv
// Restoring divider, one quotient bit per cycle, 32 steps per divide.
// Depends on ftr_pkg for the operand width.
`default_nettype none

module ftr_divider
   import ftr_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [CAP_W-1:0] dividend,
   input  wire logic [CAP_W-1:0] divisor,
   output logic                  done,
   output logic [CAP_W-1:0]      quotient
);

   localparam int CNT_W = $clog2(CAP_W);

   logic [CAP_W-1:0] rem_ff,  rem_in;
   logic [CAP_W-1:0] quot_ff, quot_in;
   logic [CAP_W-1:0] div_ff,  div_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [CAP_W:0]   rem_sh;
   logic [CAP_W:0]   diff;

   always_comb begin
      rem_sh   = {rem_ff, quot_ff[CAP_W-1]};
      diff     = rem_sh - {1'b0, div_ff};
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      div_in   = div_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = '0;
         quot_in  = dividend;
         div_in   = divisor;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (!diff[CAP_W]) begin
            rem_in  = diff[CAP_W-1:0];
            quot_in = {quot_ff[CAP_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[CAP_W-1:0];
            quot_in = {quot_ff[CAP_W-2:0], 1'b0};
         end
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_W'(CAP_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      div_ff  <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

`default_nettype wire

>>> rtl/core/ftr_chan_store.sv
// Per-fan state: last captured edge, filter accumulator and their valid bits.
// Depends on ftr_pkg for the store read/write structs.
`default_nettype none

module ftr_chan_store
   import ftr_pkg::*;
#(
   parameter int FAN_COUNT = 8
)
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire store_wr_type     wr,
   input  wire logic [FAN_W-1:0] rd_fan,
   output store_rd_type          rd
);

   localparam int IDX_W = (FAN_COUNT > 1) ? $clog2(FAN_COUNT) : 1;
   localparam int EXT_W = IDX_W + FAN_W;

   logic [CAP_W-1:0]     edge_ff [FAN_COUNT];
   logic [ACC_W-1:0]     acc_ff  [FAN_COUNT];
   logic [FAN_COUNT-1:0] seen_ff,   seen_in;
   logic [FAN_COUNT-1:0] seeded_ff, seeded_in;

   logic [EXT_W-1:0] wr_ext, rd_ext;
   logic [IDX_W-1:0] wr_idx, rd_idx;

   always_comb begin
      wr_ext    = EXT_W'(wr.fan);
      rd_ext    = EXT_W'(rd_fan);
      wr_idx    = wr_ext[IDX_W-1:0];
      rd_idx    = rd_ext[IDX_W-1:0];
      seen_in   = seen_ff;
      seeded_in = seeded_ff;
      if (wr.edge_we) seen_in[wr_idx]   = 1'b1;
      if (wr.acc_we)  seeded_in[wr_idx] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff   <= '0;
         seeded_ff <= '0;
      end else begin
         seen_ff   <= seen_in;
         seeded_ff <= seeded_in;
      end
      if (wr.edge_we) edge_ff[wr_idx] <= wr.edge_val;
      if (wr.acc_we)  acc_ff[wr_idx]  <= wr.acc_val;
   end

   // entries are only consumed when their valid bit is set
   assign rd.seen      = seen_ff[rd_idx];
   assign rd.seeded    = seeded_ff[rd_idx];
   assign rd.last_edge = edge_ff[rd_idx];
   assign rd.acc       = acc_ff[rd_idx];

endmodule

`default_nettype wire

>>> rtl/core/fan_tach_period_to_rate_filter.sv
// Top level: capture sequencer, period and filter arithmetic, result register.
// Depends on ftr_pkg, ftr_divider and ftr_chan_store.
//
//  channel | dir | handshake             | payload
//  req     | in  | req_tvalid/req_tready | tdata: fan_index, capture_value
//  rsp     | out | rsp_tvalid/rsp_tready | tdata: out_fan, filtered_rate;
//          |     |                       | tuser: stall_flag, saturate_flag
//  csr     | in  | csr_we                | csr_addr, csr_wdata
//
// A rate beat passes the check, divider (launch, 32 steps, done), filter and emit
// states, and the next capture is taken once emit is left. A first capture or
// unknown fan frees the input straight from check; a stall beat goes from check
// to emit and frees the input once emit is left. req_tready is high only while idle.
// The result register holds a beat until taken; a new capture is accepted
// meanwhile and waits in the final step if the register is still full.
// Reset is synchronous and clears all per-fan valid bits at once.
`default_nettype none

module fan_tach_period_to_rate_filter
   import ftr_pkg::*;
#(
   parameter int FAN_COUNT = 8
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [39:0]           req_tdata,   // fan_index[2:0], capture_value[34:3]
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [23:0]                rsp_tdata,   // out_fan[2:0], filtered_rate[18:3]
   output logic [1:0]                 rsp_tuser,   // stall_flag[0], saturate_flag[1]
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CMP_W = FAN_W + 2;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_CHECK = 5'b00010,
      S_DIV   = 5'b00100,
      S_FILT  = 5'b01000,
      S_EMIT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [CAP_W-1:0]   ref_clk_ff, ref_clk_in;
   logic [SHIFT_W-1:0] shift_ff,   shift_in;

   logic [FAN_W-1:0]   fan_ff,    fan_in;
   logic [CAP_W-1:0]   cap_ff,    cap_in;
   logic [CAP_W-1:0]   period_ff, period_in;
   logic [RATE_W-1:0]  res_rate_ff,  res_rate_in;
   logic               res_stall_ff, res_stall_in;
   logic               res_sat_ff,   res_sat_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [FAN_W-1:0]   rsp_fan_ff,   rsp_fan_in;
   logic [RATE_W-1:0]  rsp_rate_ff,  rsp_rate_in;
   logic               rsp_stall_ff, rsp_stall_in;
   logic               rsp_sat_ff,   rsp_sat_in;

   store_wr_type       st_wr;
   store_rd_type       st_rd;

   // divider launch, registered at the same edge as the period
   logic               div_go_ff, div_go_in;
   logic               div_done;
   logic [CAP_W-1:0]   div_quot;

   logic               req_fire;
   logic               fan_ok;
   logic               out_free;
   logic [RATE_W-1:0]  raw;
   logic               sat;
   logic [ACC_W-1:0]   acc_new;
   logic [ACC_W-1:0]   filt;

   ftr_chan_store #(
      .FAN_COUNT (FAN_COUNT)
   ) u_store (
      .clock  (clock),
      .reset  (reset),
      .wr     (st_wr),
      .rd_fan (fan_ff),
      .rd     (st_rd)
   );

   ftr_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go_ff),
      .dividend (ref_clk_ff),
      .divisor  (period_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   // configuration; shift is clamped on write, which matches clamping on use
   always_comb begin
      ref_clk_in = ref_clk_ff;
      shift_in   = shift_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_REF_CLOCK:    ref_clk_in = csr_wdata[CAP_W-1:0];
            CSR_FILTER_SHIFT: shift_in = (csr_wdata[SHIFT_W-1:0] > MAX_SHIFT) ?
                                         MAX_SHIFT : csr_wdata[SHIFT_W-1:0];
            default:          ref_clk_in = ref_clk_ff;
         endcase
      end
   end

   // rate and filter arithmetic
   always_comb begin
      // a zero period only comes from the wrap of all-ones to zero
      if (period_ff == '0) begin
         raw = '0;
         sat = 1'b0;
      end else if (div_quot[CAP_W-1:RATE_W] != '0) begin
         raw = RATE_MAX;
         sat = 1'b1;
      end else begin
         raw = div_quot[RATE_W-1:0];
         sat = 1'b0;
      end
      if (!st_rd.seeded)
         acc_new = ACC_W'(raw) << shift_ff;
      else
         acc_new = st_rd.acc - (st_rd.acc >> shift_ff) + ACC_W'(raw);
      filt = acc_new >> shift_ff;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign fan_ok     = CMP_W'(fan_ff) < CMP_W'(FAN_COUNT);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      fan_in       = fan_ff;
      cap_in       = cap_ff;
      period_in    = period_ff;
      res_rate_in  = res_rate_ff;
      res_stall_in = res_stall_ff;
      res_sat_in   = res_sat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_fan_in   = rsp_fan_ff;
      rsp_rate_in  = rsp_rate_ff;
      rsp_stall_in = rsp_stall_ff;
      rsp_sat_in   = rsp_sat_ff;
      st_wr        = '0;
      st_wr.fan      = fan_ff;
      st_wr.edge_val = cap_ff;
      st_wr.acc_val  = acc_new;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               fan_in   = req_tdata[FAN_W-1:0];
               cap_in   = req_tdata[FAN_W+CAP_W-1:FAN_W];
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (!fan_ok) begin
               state_in = S_IDLE;
            end else begin
               st_wr.edge_we = 1'b1;
               if (!st_rd.seen) begin
                  state_in = S_IDLE;
               end else if (cap_ff == st_rd.last_edge) begin
                  res_rate_in  = '0;
                  res_stall_in = 1'b1;
                  res_sat_in   = 1'b0;
                  state_in     = S_EMIT;
               end else begin
                  if (cap_ff > st_rd.last_edge)
                     period_in = cap_ff - st_rd.last_edge;
                  else
                     period_in = (WRAP_LIMIT - st_rd.last_edge) + cap_ff;
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            // first cycle here launches the divide; period_ff is settled
            if (div_done)
               state_in = S_FILT;
         end
         S_FILT: begin
            st_wr.acc_we = 1'b1;
            res_rate_in  = (filt[ACC_W-1:RATE_W] != '0) ? RATE_MAX : filt[RATE_W-1:0];
            res_stall_in = 1'b0;
            res_sat_in   = sat;
            state_in     = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_fan_in   = fan_ff;
               rsp_rate_in  = res_rate_ff;
               rsp_stall_in = res_stall_ff;
               rsp_sat_in   = res_sat_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign div_go_in = (state_ff == S_CHECK) && (state_in == S_DIV);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         div_go_ff    <= 1'b0;
         ref_clk_ff   <= REF_CLOCK_RESET;
         shift_ff     <= SHIFT_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         div_go_ff    <= div_go_in;
         ref_clk_ff   <= ref_clk_in;
         shift_ff     <= shift_in;
      end
      fan_ff       <= fan_in;
      cap_ff       <= cap_in;
      period_ff    <= period_in;
      res_rate_ff  <= res_rate_in;
      res_stall_ff <= res_stall_in;
      res_sat_ff   <= res_sat_in;
      rsp_fan_ff   <= rsp_fan_in;
      rsp_rate_ff  <= rsp_rate_in;
      rsp_stall_ff <= rsp_stall_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_rate_ff, rsp_fan_ff};
   assign rsp_tuser  = {rsp_sat_ff, rsp_stall_ff};

endmodule

`default_nettype wire
